// ===== rtl/core/rtw_pkg.sv =====
// ----------------------------------------------------------------------------
// rtw_pkg
// Shared types and constants for the RTP timestamp to wall clock mapper.
// ----------------------------------------------------------------------------
package rtw_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_PERIOD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_TOL       = 8'd3;

    localparam logic [31:0] CLOCK_RATE_RST    = 32'd90000;
    localparam logic [15:0] UPDATE_PERIOD_RST = 16'd1000;
    localparam logic [15:0] CORR_PERIOD_RST   = 16'd10;
    localparam logic [15:0] LAG_TOL_RST       = 16'd15;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH,
        OP_AVG_GO,
        OP_AVG_ZERO,
        OP_AVG_TAKE,
        OP_PASS,
        OP_SUM_PRED,
        OP_SUM_RES,
        OP_MUL,
        OP_DIV_GO,
        OP_CONV_ZERO,
        OP_CONV_TAKE,
        OP_SUM_BASE,
        OP_CHECK,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic count_nz;
        logic rate_zero;
        logic div_done;
        logic do_check;
        logic resync_hit;
        logic out_full;
    } status_t;

endpackage

// ===== rtl/core/rtw_if.sv =====
// ----------------------------------------------------------------------------
// rtw interfaces
// Request channels: input items, result items, and register writes.
// ----------------------------------------------------------------------------
interface rtw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] rtp_time;
    logic [63:0] wall_ms;

    modport source (output valid, output rtp_time, output wall_ms, input ready);
    modport sink (input valid, input rtp_time, input wall_ms, output ready);
endinterface

interface rtw_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] stream_ms;

    modport source (output valid, output stream_ms, input ready);
    modport sink (input valid, input stream_ms, output ready);
endinterface

interface rtw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rtw_pkg::CFG_IDX_W-1:0]  index;
    logic [rtw_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rtw_div.sv =====
// ----------------------------------------------------------------------------
// rtw_div
// Restoring divider, 64-bit dividend by 32-bit nonzero divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module rtw_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, q_reg[63]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[62:0], fits};
            if (fits)
                rem_reg <= 32'(shifted - {1'b0, dvs_reg});
            else
                rem_reg <= shifted[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/core/rtw_datapath.sv =====
// ----------------------------------------------------------------------------
// rtw_datapath
// Timing state, step window memory, shared divider and result register.
// ----------------------------------------------------------------------------
module rtw_datapath #(
    parameter int WINDOW = 1000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rtw_pkg::cmd_t   cmd,
    output rtw_pkg::status_t status,
    rtw_in_if.sink          in_item,
    rtw_out_if.source       out_item,
    rtw_cfg_if.sink         cfg
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = 32 + CNT_W;

    logic [31:0] clock_rate_reg;
    logic [15:0] update_period_reg;
    logic [15:0] corr_period_reg;
    logic [15:0] lag_tol_reg;

    logic [63:0] base_reg;
    logic [63:0] accum_reg;
    logic [63:0] last_reg;
    logic [31:0] prev_rtp_reg;
    logic        prev_valid_reg;
    logic [15:0] countdown_reg;
    logic [PTR_W-1:0] pos_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic        resynced_reg;
    logic        out_valid_reg;

    logic [31:0] rtp_reg;
    logic [63:0] now_reg;
    logic [31:0] rd_reg;
    logic [31:0] avg_reg;
    logic [63:0] t_reg;
    logic [63:0] prod_reg;
    logic [63:0] conv_reg;
    logic [63:0] pred_reg;
    logic [63:0] out_data_reg;

    logic [31:0] ring [WINDOW];

    logic [31:0] diff;
    logic [31:0] mag;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_dvd;
    logic [31:0] div_dvs;
    logic [63:0] div_q;
    logic        ahead;
    logic        hit;

    assign diff = in_item.rtp_time - prev_rtp_reg;
    assign mag  = rtp_reg - prev_rtp_reg;
    assign ahead = pred_reg > now_reg;
    assign hit  = !ahead && ((now_reg - pred_reg) > {48'd0, lag_tol_reg}) && !resynced_reg;

    assign div_start = (cmd.op == rtw_pkg::OP_AVG_GO) || (cmd.op == rtw_pkg::OP_DIV_GO);
    assign div_dvd = (cmd.op == rtw_pkg::OP_AVG_GO) ?
                     {{(64-SUM_W){1'b0}}, sum_reg} : prod_reg;
    assign div_dvs = (cmd.op == rtw_pkg::OP_AVG_GO) ?
                     {{(32-CNT_W){1'b0}}, count_reg} : clock_rate_reg;

    rtw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg    <= rtw_pkg::CLOCK_RATE_RST;
            update_period_reg <= rtw_pkg::UPDATE_PERIOD_RST;
            corr_period_reg   <= rtw_pkg::CORR_PERIOD_RST;
            lag_tol_reg       <= rtw_pkg::LAG_TOL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rtw_pkg::CFG_CLOCK_RATE:    clock_rate_reg    <= cfg.data;
                rtw_pkg::CFG_UPDATE_PERIOD: update_period_reg <= cfg.data[15:0];
                rtw_pkg::CFG_CORR_PERIOD:   corr_period_reg   <= cfg.data[15:0];
                rtw_pkg::CFG_LAG_TOL:       lag_tol_reg       <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= '0;
            accum_reg      <= '0;
            last_reg       <= '0;
            prev_rtp_reg   <= '0;
            prev_valid_reg <= 1'b0;
            countdown_reg  <= rtw_pkg::UPDATE_PERIOD_RST;
            pos_reg        <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            resynced_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_item.ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                rtw_pkg::OP_LOAD:
                begin
                    resynced_reg <= 1'b0;
                    if (diff > clock_rate_reg)
                    begin
                        prev_valid_reg <= 1'b0;
                        countdown_reg  <= update_period_reg;
                    end
                end
                rtw_pkg::OP_PUSH:
                begin
                    if (prev_valid_reg)
                    begin
                        if (count_reg == CNT_W'(WINDOW))
                            sum_reg <= sum_reg - {{(SUM_W-32){1'b0}}, rd_reg}
                                       + {{(SUM_W-32){1'b0}}, (mag[31] ? -mag : mag)};
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            sum_reg <= sum_reg + {{(SUM_W-32){1'b0}}, (mag[31] ? -mag : mag)};
                        end
                        if (pos_reg == PTR_W'(WINDOW - 1))
                            pos_reg <= '0;
                        else
                            pos_reg <= pos_reg + PTR_W'(1);
                    end
                end
                rtw_pkg::OP_PASS:
                begin
                    if (!prev_valid_reg)
                    begin
                        base_reg  <= now_reg;
                        accum_reg <= '0;
                    end
                    if (countdown_reg > 16'd1)
                    begin
                        countdown_reg <= countdown_reg - 16'd1;
                        if (prev_valid_reg)
                            accum_reg <= accum_reg + {32'd0, avg_reg};
                    end
                end
                rtw_pkg::OP_CHECK:
                begin
                    if (ahead)
                    begin
                        countdown_reg <= corr_period_reg;
                        accum_reg <= accum_reg + {33'd0, avg_reg[31:1]};
                    end
                    else if (hit)
                    begin
                        prev_valid_reg <= 1'b0;
                        countdown_reg  <= corr_period_reg;
                        resynced_reg   <= 1'b1;
                    end
                    else
                    begin
                        countdown_reg <= update_period_reg;
                        accum_reg <= accum_reg + {32'd0, avg_reg};
                    end
                end
                rtw_pkg::OP_OUT:
                begin
                    last_reg       <= (pred_reg <= last_reg) ? last_reg + 64'd1 : pred_reg;
                    out_valid_reg  <= 1'b1;
                    prev_rtp_reg   <= rtp_reg;
                    prev_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // per-item scratch and window memory
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            rtw_pkg::OP_LOAD:
            begin
                rtp_reg <= in_item.rtp_time;
                now_reg <= in_item.wall_ms;
                rd_reg  <= ring[pos_reg];
            end
            rtw_pkg::OP_PUSH:
            begin
                if (prev_valid_reg)
                    ring[pos_reg] <= mag[31] ? -mag : mag;
            end
            rtw_pkg::OP_AVG_ZERO:  avg_reg  <= '0;
            rtw_pkg::OP_AVG_TAKE:  avg_reg  <= div_q[31:0];
            rtw_pkg::OP_SUM_PRED:  t_reg    <= accum_reg + {32'd0, avg_reg};
            rtw_pkg::OP_SUM_RES:   t_reg    <= accum_reg;
            rtw_pkg::OP_MUL:       prod_reg <= (t_reg << 10) - (t_reg << 5) + (t_reg << 3);
            rtw_pkg::OP_CONV_ZERO: conv_reg <= '0;
            rtw_pkg::OP_CONV_TAKE: conv_reg <= div_q;
            rtw_pkg::OP_SUM_BASE:  pred_reg <= base_reg + conv_reg;
            rtw_pkg::OP_OUT:
                out_data_reg <= (pred_reg <= last_reg) ? last_reg + 64'd1 : pred_reg;
            default: ;
        endcase
    end

    assign status.count_nz   = count_reg != '0;
    assign status.rate_zero  = clock_rate_reg == '0;
    assign status.div_done   = div_done;
    assign status.do_check   = countdown_reg <= 16'd1;
    assign status.resync_hit = hit;
    assign status.out_full   = out_valid_reg;

    assign out_item.valid     = out_valid_reg;
    assign out_item.stream_ms = out_data_reg;

endmodule

// ===== rtl/core/rtw_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtw_ctrl
// Sequencer: steps the datapath through one item per request.
// ----------------------------------------------------------------------------
module rtw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtw_pkg::status_t status,
    output rtw_pkg::cmd_t    cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PUSH  = 5'd1;
    localparam logic [4:0] S_AVG   = 5'd2;
    localparam logic [4:0] S_AVGW  = 5'd3;
    localparam logic [4:0] S_PASS  = 5'd4;
    localparam logic [4:0] S_PSUM  = 5'd5;
    localparam logic [4:0] S_PMUL  = 5'd6;
    localparam logic [4:0] S_PDIV  = 5'd7;
    localparam logic [4:0] S_PWAIT = 5'd8;
    localparam logic [4:0] S_PRED  = 5'd9;
    localparam logic [4:0] S_CHECK = 5'd10;
    localparam logic [4:0] S_RSUM  = 5'd11;
    localparam logic [4:0] S_RMUL  = 5'd12;
    localparam logic [4:0] S_RDIV  = 5'd13;
    localparam logic [4:0] S_RWAIT = 5'd14;
    localparam logic [4:0] S_RES   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = rtw_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op = rtw_pkg::OP_LOAD;
                    state_next = S_PUSH;
                end
            S_PUSH:
            begin
                cmd.op = rtw_pkg::OP_PUSH;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                cmd.op = status.count_nz ? rtw_pkg::OP_AVG_GO : rtw_pkg::OP_AVG_ZERO;
                state_next = status.count_nz ? S_AVGW : S_PASS;
            end
            S_AVGW:
                if (status.div_done)
                begin
                    cmd.op = rtw_pkg::OP_AVG_TAKE;
                    state_next = S_PASS;
                end
            S_PASS:
            begin
                cmd.op = rtw_pkg::OP_PASS;
                state_next = status.do_check ? S_PSUM : S_RSUM;
            end
            S_PSUM:
            begin
                cmd.op = rtw_pkg::OP_SUM_PRED;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.op = rtw_pkg::OP_MUL;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                cmd.op = status.rate_zero ? rtw_pkg::OP_CONV_ZERO : rtw_pkg::OP_DIV_GO;
                state_next = status.rate_zero ? S_PRED : S_PWAIT;
            end
            S_PWAIT:
                if (status.div_done)
                begin
                    cmd.op = rtw_pkg::OP_CONV_TAKE;
                    state_next = S_PRED;
                end
            S_PRED:
            begin
                cmd.op = rtw_pkg::OP_SUM_BASE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // a lag resync reruns the pass with the new base
                cmd.op = rtw_pkg::OP_CHECK;
                state_next = status.resync_hit ? S_PASS : S_RSUM;
            end
            S_RSUM:
            begin
                cmd.op = rtw_pkg::OP_SUM_RES;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                cmd.op = rtw_pkg::OP_MUL;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                cmd.op = status.rate_zero ? rtw_pkg::OP_CONV_ZERO : rtw_pkg::OP_DIV_GO;
                state_next = status.rate_zero ? S_RES : S_RWAIT;
            end
            S_RWAIT:
                if (status.div_done)
                begin
                    cmd.op = rtw_pkg::OP_CONV_TAKE;
                    state_next = S_RES;
                end
            S_RES:
            begin
                cmd.op = rtw_pkg::OP_SUM_BASE;
                state_next = S_OUT;
            end
            S_OUT:
                if (!status.out_full)
                begin
                    cmd.op = rtw_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/rtp_timestamp_to_wallclock.sv =====
// ----------------------------------------------------------------------------
// rtp_timestamp_to_wallclock
// Maps RTP media timestamps to strictly increasing epoch milliseconds.
// ----------------------------------------------------------------------------
// Every divide runs on the single shared bit-serial divider.
// Throughput: one request at a time; the next is taken once the result sits
// in the output register. Reset: async active low, state and configuration
// registers to their defaults; the step window memory and the per-item
// scratch registers are not cleared.
module rtp_timestamp_to_wallclock #(
    parameter int WINDOW = 1000
) (
    input  logic      clk,
    input  logic      rst_n,
    rtw_in_if.sink    in_item,
    rtw_out_if.source out_item,
    rtw_cfg_if.sink   cfg
);

    rtw_pkg::cmd_t    cmd;
    rtw_pkg::status_t status;

    // sequencer: one datapath op per cycle, none while it waits on the divider or a full output register
    rtw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: window ring, running sum, accumulator, divider, output reg
    rtw_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_item  (in_item),
        .out_item (out_item),
        .cfg      (cfg)
    );

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_item.valid && in_item.ready |=> !in_item.ready)
        else $error("second request accepted while busy");

    // a new result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == rtw_pkg::OP_OUT |-> !status.out_full)
        else $error("result register overwritten");

    // a shown result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid && !out_item.ready |=> out_item.valid && $stable(out_item.stream_ms))
        else $error("result dropped before taken");

endmodule

// ===== tb/rtp_timestamp_to_wallclock_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_timestamp_to_wallclock_tb
// Drives media timestamp / wall time requests through the mapper and checks
// every stream time against an in-bench prediction of the step window,
// tick accumulator, drift checks and resyncs, under several register
// settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module rtp_timestamp_to_wallclock_tb;

    localparam int          WIN         = 1000;
    localparam int          DRAIN_WAIT  = 400;     // > worst request latency
    localparam longint      CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [31:0] rtp;
        logic [63:0] wall;
    } media_req_t;

    logic clk;
    logic rst_n;

    rtw_in_if  in_item ();
    rtw_out_if out_item ();
    rtw_cfg_if cfg ();

    rtp_timestamp_to_wallclock #(.WINDOW(WIN)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item),
        .cfg      (cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Shadow of the mapper: registers and state
    // ------------------------------------------------------------------------
    logic [31:0] m_rate;
    logic [31:0] m_upd_period;
    logic [31:0] m_corr_period;
    logic [31:0] m_lag_tol;
    logic [63:0] m_base;
    logic [63:0] m_ticks;
    logic [63:0] m_last_out;
    logic [31:0] m_prev_rtp;
    logic        m_prev_ok;
    logic [31:0] m_countdown;
    logic [31:0] m_steps [WIN];
    int          m_pos;
    int          m_count;
    logic [63:0] m_sum;

    media_req_t  pending_reqs [$];
    logic [63:0] expected_stream_ms [$];

    int     errors;
    int     sender_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;
    longint cycle_cnt;

    function automatic logic [63:0] ticks_ms(input logic [63:0] ticks);
        if (m_rate == 32'd0)
            return 64'd0;
        return (ticks * 64'd1000) / {32'd0, m_rate};
    endfunction

    // Advance the shadow state by one request and queue its stream time.
    task automatic map_request(input logic [31:0] rtp, input logic [63:0] now);
        logic [31:0] diff;
        logic [31:0] mag;
        logic [31:0] avg;
        logic [63:0] pred;
        logic [63:0] res;
        logic        resynced;
        logic        done;
        diff = rtp - m_prev_rtp;
        resynced = 1'b0;
        if (diff > m_rate)
        begin
            m_prev_ok = 1'b0;
            m_countdown = m_upd_period;
        end
        if (m_prev_ok)
        begin
            // magnitude of the signed step; 2^31 negates to itself
            mag = diff[31] ? (32'd0 - diff) : diff;
            if (m_count >= WIN)
                m_sum = m_sum - {32'd0, m_steps[m_pos]};
            else
                m_count++;
            m_steps[m_pos] = mag;
            m_sum = m_sum + {32'd0, mag};
            m_pos = (m_pos + 1 >= WIN) ? 0 : m_pos + 1;
        end
        avg = (m_count > 0) ? 32'(m_sum / 64'(m_count)) : 32'd0;
        done = 1'b0;
        while (!done)
        begin
            done = 1'b1;
            if (!m_prev_ok)
            begin
                m_base = now;
                m_ticks = 64'd0;
            end
            if (m_countdown <= 32'd1)
            begin
                pred = m_base + ticks_ms(m_ticks + {32'd0, avg});
                m_countdown = m_upd_period;
                if (pred > now)
                begin
                    // running ahead: half step, look again soon
                    m_countdown = m_corr_period;
                    m_ticks = m_ticks + {32'd0, avg / 2};
                end
                else if ((now - pred) > {32'd0, m_lag_tol} && !resynced)
                begin
                    // lagging: rebase on wall time and redo this request
                    m_prev_ok = 1'b0;
                    m_countdown = m_corr_period;
                    resynced = 1'b1;
                    done = 1'b0;
                end
                else
                    m_ticks = m_ticks + {32'd0, avg};
            end
            else
            begin
                m_countdown = m_countdown - 32'd1;
                if (m_prev_ok)
                    m_ticks = m_ticks + {32'd0, avg};
            end
        end
        res = m_base + ticks_ms(m_ticks);
        if (res <= m_last_out)
            res = m_last_out + 64'd1;
        m_last_out = res;
        m_prev_rtp = rtp;
        m_prev_ok = 1'b1;
        expected_stream_ms.push_back(res);
    endtask

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: one NBA per signal per edge
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        media_req_t nxt;
        logic       take;
        if (!rst_n)
        begin
            in_item.valid    <= 1'b0;
            in_item.rtp_time <= '0;
            in_item.wall_ms  <= '0;
        end
        else
        begin
            take = !in_item.valid;
            if (in_item.valid && in_item.ready)
            begin
                map_request(in_item.rtp_time, in_item.wall_ms);
                take = 1'b1;
            end
            if (take)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    in_item.valid    <= 1'b1;
                    in_item.rtp_time <= nxt.rtp;
                    in_item.wall_ms  <= nxt.wall;
                end
                else
                    in_item.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // ------------------------------------------------------------------------
    // Result monitor and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
            out_item.ready <= 1'b0;
        else
        begin
            if (out_item.valid && out_item.ready)
            begin
                if (expected_stream_ms.size() == 0)
                    report($sformatf("unexpected result stream_ms=%0d",
                                     out_item.stream_ms));
                else
                begin
                    want = expected_stream_ms.pop_front();
                    if (out_item.stream_ms !== want)
                        report($sformatf("stream_ms got %0d want %0d",
                                         out_item.stream_ms, want));
                end
            end
            out_item.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [rtw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        forever
        begin
            @(posedge clk);
            if (cfg.ready)
                break;
        end
        cfg.valid <= 1'b0;
        case (idx)
            rtw_pkg::CFG_CLOCK_RATE:    m_rate        = val;
            rtw_pkg::CFG_UPDATE_PERIOD: m_upd_period  = {16'd0, val[15:0]};
            rtw_pkg::CFG_CORR_PERIOD:   m_corr_period = {16'd0, val[15:0]};
            rtw_pkg::CFG_LAG_TOL:       m_lag_tol     = {16'd0, val[15:0]};
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] rate, input logic [15:0] upd,
                            input logic [15:0] corr, input logic [15:0] lag);
        write_reg(rtw_pkg::CFG_CLOCK_RATE, rate);
        write_reg(rtw_pkg::CFG_UPDATE_PERIOD, {16'd0, upd});
        write_reg(rtw_pkg::CFG_CORR_PERIOD, {16'd0, corr});
        write_reg(rtw_pkg::CFG_LAG_TOL, {16'd0, lag});
    endtask

    task automatic push_req(input logic [31:0] rtp, input logic [63:0] wall);
        media_req_t r;
        r.rtp  = rtp;
        r.wall = wall;
        pending_reqs.push_back(r);
    endtask

    // Mostly a steady stream (~50 packets/s) with jitter; the rest is
    // random noise, jumps past clock_rate and small backward steps.
    task automatic fill_stream(input int n, input logic [63:0] wall0);
        logic [31:0] rtp;
        logic [31:0] nominal;
        logic [63:0] wall;
        int          kind;
        rtp  = $urandom;
        wall = wall0;
        nominal = (m_rate / 50 == 0) ? 32'd1 : m_rate / 50;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                rtp  = rtp + nominal + $urandom_range(4) - 2;
                wall = wall + $urandom_range(25, 15);
            end
            else if (kind < 88)
            begin
                rtp  = $urandom;
                wall = {$urandom, $urandom};
            end
            else if (kind < 94)
            begin
                rtp  = rtp + m_rate + 32'd1 + $urandom_range(1000);
                wall = wall + $urandom_range(3000);
            end
            else
            begin
                rtp  = rtp - $urandom_range(200);
                wall = wall + $urandom_range(5);
            end
            push_req(rtp, wall);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || in_item.valid || expected_stream_ms.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        errors = 0;
        cycle_cnt = 0;
        hold_cycles = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        rst_n = 1'b0;

        m_rate = rtw_pkg::CLOCK_RATE_RST;
        m_upd_period = {16'd0, rtw_pkg::UPDATE_PERIOD_RST};
        m_corr_period = {16'd0, rtw_pkg::CORR_PERIOD_RST};
        m_lag_tol = {16'd0, rtw_pkg::LAG_TOL_RST};
        m_base = '0;
        m_ticks = '0;
        m_last_out = '0;
        m_prev_rtp = '0;
        m_prev_ok = 1'b0;
        m_countdown = {16'd0, rtw_pkg::UPDATE_PERIOD_RST};
        m_pos = 0;
        m_count = 0;
        m_sum = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        push_req(32'd0, 64'd0);
        push_req(32'd3000, 64'd33);
        push_req(32'd6000, 64'd66);
        push_req(32'd6000, 64'd67);                      // zero step
        push_req(32'd5900, 64'd68);                      // backward step
        push_req(32'h8000_176C, 64'd100);                // half-range jump
        push_req(32'hFFFF_F000, 64'hFFFF_FFFF_FFFF_FFF0);// jump, wall near top
        push_req(32'h0000_0400, 64'hFFFF_FFFF_FFFF_FFFF);// wraps mod 2^32
        push_req(32'h0000_1000, 64'd0);                  // wall back to zero
        push_req(32'hFFFF_FFFF, 64'd5);
        push_req(32'h0000_0000, 64'd6);
        push_req(32'h7FFF_FFFF, 64'hAAAA_5555_AAAA_5555);
        push_req(32'h7FFF_FFFF, 64'h5555_AAAA_5555_AAAA);
        drain();

        // frequent checks; resyncs and half steps both show up
        set_regs(32'd48000, 16'd50, 16'd5, 16'd15);
        fill_stream(150, 64'd1_700_000_000_000);
        drain();

        // smallest registers, sender idling
        sender_idle_pct = 61;
        set_regs(32'd1, 16'd1, 16'd1, 16'd0);
        fill_stream(100, 64'hFFFF_FFFF_FFFF_F000);
        drain();

        // largest registers, receiver stalling
        sender_idle_pct = 0;
        recv_stall_pct = 61;
        set_regs(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        fill_stream(80, 64'd1_000_000);
        drain();

        // both idle; receiver held off so the block backs up its input
        sender_idle_pct = 30;
        recv_stall_pct = 30;
        set_regs(32'd90000, 16'd3, 16'd2, 16'd5);
        fill_stream(200, {$urandom, $urandom});
        hold_cycles = 2000;
        drain();

        // back near defaults, no idling
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        set_regs(32'd8000, 16'd1000, 16'd10, 16'd15);
        fill_stream(70, 64'd42);
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
